// ===== hw/rtl/ssp_pkg.sv =====
// Package for the seeded shuffle permutation block: widths, hash constants,
// command/status/register codes and the request and response beat types.
// No dependencies.
package ssp_pkg;

   localparam int MAX_UNITS = 1024;
   localparam int IDX_W     = $clog2(MAX_UNITS);
   localparam int CNT_W     = 11;
   localparam int SEED_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [63:0] GOLDEN_K = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_K1   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_K2   = 64'h94d0_49bb_1331_11eb;

   localparam int SHIFT_A = 30;
   localparam int SHIFT_B = 27;
   localparam int SHIFT_C = 31;

   // fraction is the top FRAC_W bits of the hash
   localparam int FRAC_W = 24;

   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHUFFLE_SEED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_COUNT   = 1'b1;

   typedef struct packed {
      logic             command;
      logic [IDX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ===== hw/rtl/ssp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/seeded_shuffle_permutation.sv =====
// Seeded shuffle permutation: one build of N entries (N is unit_count at the build command,
// capped at 1024) runs the setup states PRE0 and PRE1, an identity fill of all N entries and,
// when N is two or more, N-1 swaps, then loads the response. Each swap hashes on one shared
// 32x32 multiplier (a seed mix, then three xor-shift rounds, the first two followed by a
// 64-bit product built from three partial products with a register after each), forms the
// scaled index (multiply, select) and then works on the single-port-per-direction
// permutation RAM (two reads, two writes). A read command does a registered RAM read and
// then loads the response register. The block takes one command at a time; a response
// waiting on rsp_stall holds off the next command. Depends on ssp_pkg and ssp_ram.
module seeded_shuffle_permutation
   import ssp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEED_W-1:0]    csr_wdata
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RRESP = 5'd1;
   localparam logic [4:0] ST_PRE0  = 5'd2;
   localparam logic [4:0] ST_PRE1  = 5'd3;
   localparam logic [4:0] ST_FILL  = 5'd4;
   localparam logic [4:0] ST_MIX   = 5'd5;
   localparam logic [4:0] ST_XS    = 5'd6;
   localparam logic [4:0] ST_P0    = 5'd7;
   localparam logic [4:0] ST_A0    = 5'd8;
   localparam logic [4:0] ST_P1    = 5'd9;
   localparam logic [4:0] ST_A1    = 5'd10;
   localparam logic [4:0] ST_P2    = 5'd11;
   localparam logic [4:0] ST_A2    = 5'd12;
   localparam logic [4:0] ST_JM    = 5'd13;
   localparam logic [4:0] ST_JSEL  = 5'd14;
   localparam logic [4:0] ST_RDHI  = 5'd15;
   localparam logic [4:0] ST_RDJ   = 5'd16;
   localparam logic [4:0] ST_WRHI  = 5'd17;
   localparam logic [4:0] ST_WRJ   = 5'd18;
   localparam logic [4:0] ST_DONE  = 5'd19;

   localparam logic [1:0] PASS_K1  = 2'd0;
   localparam logic [1:0] PASS_K2  = 2'd1;
   localparam logic [1:0] PASS_FIN = 2'd2;

   logic [4:0]          state_ff, state_in;
   logic [SEED_W-1:0]   seed_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                built_ff;
   logic [CNT_W-1:0]    built_count_ff;
   logic [CNT_W-1:0]    i_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [1:0]          pass_ff;
   logic [IDX_W-1:0]    j_ff;
   logic [IDX_W-1:0]    t_ff;
   logic [63:0]         sconst_ff;
   logic [63:0]         acc_ff;
   logic [63:0]         x_ff;
   logic [63:0]         prod_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_load;

   logic                req_accept;
   logic [CNT_W-1:0]    sat_count;
   logic [IDX_W-1:0]    hi;
   logic [CNT_W-1:0]    j_full;
   logic [63:0]         mix_k;
   logic [63:0]         xs_val;
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_prod;
   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr, ram_wr_data, ram_rd_data;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign sat_count = (count_ff > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : count_ff;
   assign hi        = IDX_W'(i_ff - CNT_W'(1));
   assign j_full    = prod_ff[FRAC_W +: CNT_W];
   assign mix_k     = (pass_ff == PASS_K1) ? MIX_K1 : MIX_K2;

   always_comb begin
      unique case (pass_ff)
         PASS_K1:  xs_val = acc_ff ^ (acc_ff >> SHIFT_A);
         PASS_K2:  xs_val = acc_ff ^ (acc_ff >> SHIFT_B);
         default:  xs_val = acc_ff ^ (acc_ff >> SHIFT_C);
      endcase
   end

   // Shared multiplier: low 64 bits of a 64x64 product come from three partial products.
   always_comb begin
      unique case (state_ff)
         ST_P0: begin
            mul_a = x_ff[31:0];
            mul_b = mix_k[31:0];
         end
         ST_P1: begin
            mul_a = x_ff[31:0];
            mul_b = mix_k[63:32];
         end
         ST_P2: begin
            mul_a = x_ff[63:32];
            mul_b = mix_k[31:0];
         end
         ST_JM: begin
            mul_a = 32'(i_ff);
            mul_b = 32'(x_ff[63:64-FRAC_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_data.command == CMD_READ) ? ST_RRESP : ST_PRE0;
            end
         end
         ST_RRESP: state_in = ST_IDLE;
         ST_PRE0:  state_in = ST_PRE1;
         ST_PRE1:  state_in = (built_count_ff == '0) ? ST_DONE : ST_FILL;
         ST_FILL: begin
            if (fill_ff == built_count_ff - CNT_W'(1)) begin
               state_in = (built_count_ff > CNT_W'(1)) ? ST_MIX : ST_DONE;
            end
         end
         ST_MIX:  state_in = ST_XS;
         ST_XS:   state_in = (pass_ff == PASS_FIN) ? ST_JM : ST_P0;
         ST_P0:   state_in = ST_A0;
         ST_A0:   state_in = ST_P1;
         ST_P1:   state_in = ST_A1;
         ST_A1:   state_in = ST_P2;
         ST_P2:   state_in = ST_A2;
         ST_A2:   state_in = ST_XS;
         ST_JM:   state_in = ST_JSEL;
         ST_JSEL: state_in = ST_RDHI;
         ST_RDHI: state_in = ST_RDJ;
         ST_RDJ:  state_in = ST_WRHI;
         ST_WRHI: state_in = ST_WRJ;
         ST_WRJ:  state_in = (i_ff > CNT_W'(2)) ? ST_MIX : ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      if (state_ff == ST_RRESP) begin
         rsp_load      = 1'b1;
         rsp_in.status = status_ff;
         rsp_in.value  = (status_ff == STATUS_OK) ? ram_rd_data : '0;
      end else if (state_ff == ST_DONE) begin
         rsp_load      = 1'b1;
         rsp_in.status = STATUS_OK;
         rsp_in.value  = '0;
      end
   end

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      priority case (1'b1)
         req_accept && (req_data.command == CMD_READ): begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = req_data.index;
         end
         state_ff == ST_RDHI: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = hi;
         end
         state_ff == ST_RDJ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff;
         end
         state_ff == ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff[IDX_W-1:0];
            ram_wr_data = fill_ff[IDX_W-1:0];
         end
         state_ff == ST_WRHI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi;
            ram_wr_data = ram_rd_data;
         end
         state_ff == ST_WRJ: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = t_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         count_ff     <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SHUFFLE_SEED: seed_ff  <= csr_wdata;
               CSR_UNIT_COUNT:   count_ff <= csr_wdata[CNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_DONE) begin
            built_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (req_accept) begin
         if (req_data.command == CMD_READ) begin
            if (!built_ff) begin
               status_ff <= STATUS_NOT_BUILT;
            end else if (CNT_W'(req_data.index) >= built_count_ff) begin
               status_ff <= STATUS_RANGE;
            end else begin
               status_ff <= STATUS_OK;
            end
         end else begin
            built_count_ff <= sat_count;
            i_ff           <= sat_count;
         end
      end
      prod_ff <= mul_prod;
      unique case (state_ff)
         ST_PRE0: sconst_ff <= (seed_ff << 6) + (seed_ff >> 2);
         ST_PRE1: begin
            sconst_ff <= sconst_ff + GOLDEN_K;
            fill_ff   <= '0;
         end
         ST_FILL: fill_ff <= fill_ff + CNT_W'(1);
         ST_MIX: begin
            acc_ff  <= seed_ff ^ (64'(hi) + sconst_ff);
            pass_ff <= PASS_K1;
         end
         ST_XS:   x_ff <= xs_val;
         ST_A0:   acc_ff <= prod_ff;
         ST_A1:   acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
         ST_A2: begin
            acc_ff  <= acc_ff + {prod_ff[31:0], 32'd0};
            pass_ff <= pass_ff + 2'd1;
         end
         ST_JSEL: j_ff <= (j_full >= i_ff) ? hi : j_full[IDX_W-1:0];
         ST_RDJ:  t_ff <= ram_rd_data;    // entry at hi, read in ST_RDHI
         ST_WRJ:  i_ff <= i_ff - CNT_W'(1);
         default: begin
         end
      endcase
   end

   ssp_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_UNITS)
   ) u_perm_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== hw/rtl/ssp_checker.sv =====
// Port-level checks for seeded_shuffle_permutation, bound to the top level.
// Depends on ssp_pkg.
module ssp_checker
   import ssp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data
);

   // a held response beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // a read beat is answered after the registered RAM read and the response register load
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == CMD_READ) |-> ##2 rsp_valid)
      else $error("read response missing two cycles after accept");

   // the block takes one command at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous command in flight");

   // responses with an error status (failed reads) carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> (rsp_data.value == '0))
      else $error("error response with nonzero value");

endmodule

bind seeded_shuffle_permutation ssp_checker u_ssp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
